@@ src/sst_pkg.sv @@
package sst_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int MAX_DIM      = 1024;

   localparam int ROW_W       = 10;
   localparam int COL_W       = 10;
   localparam int VAL_W       = 32;
   localparam int CFG_W       = 11;
   localparam int STATUS_W    = 3;
   localparam int STORED_W    = 7;
   localparam int CSR_INDEX_W = 1;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ROW_OOB   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_COL_OOB   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [ROW_W-1:0]        row_index;
      logic [COL_W-1:0]        column_index;
      logic signed [VAL_W-1:0] term_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [VAL_W-1:0] read_value;
      logic [STORED_W-1:0]     stored_terms;
   } rsp_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        column;
      logic signed [VAL_W-1:0] value;
   } term_type;

endpackage

@@ src/sst_term_ram.sv @@
module sst_term_ram #(
   parameter int DEPTH = sst_pkg::DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  sst_pkg::term_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output sst_pkg::term_type        rd_data
);

   sst_pkg::term_type mem [DEPTH];
   sst_pkg::term_type rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/sorted_sparse_term_store.sv @@
// Channel   Ports                        Direction  Beat taken when
// -------   --------------------------   ---------  ---------------------------
// request   start, busy, req_data         in         start high and busy low
// response  rsp_valid, rsp_data           out        every cycle rsp_valid is high
// csr       csr_write, csr_index, csr_data in        every cycle csr_write is high
//
// A rejected insert (bounds or full) answers in the cycle after the request beat.
// Inserts walk the table downwards from the last term, moving each later key up
// one place; lookups walk upwards from the first. The term RAM reads one entry and
// writes one per cycle. Reset is synchronous, clears the term count and sets both
// dimension registers to the largest size; the RAM needs no clearing. The receiver
// cannot stall: each response beat is shown for exactly one cycle, and busy alone
// holds off requests.
module sorted_sparse_term_store #(
   parameter int CAPACITY = sst_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  sst_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output sst_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [sst_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sst_pkg::CFG_W-1:0]           csr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      IDLE,
      INS_WALK,
      INS_PUT,
      LK_WALK
   } state_type;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 cur_ff, cur_in;
   logic [CW-1:0]                 count_ff, count_in;
   sst_pkg::req_type              req_ff, req_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sst_pkg::rsp_type              rsp_ff, rsp_in;
   logic [sst_pkg::CFG_W-1:0]     row_count_ff, row_count_in;
   logic [sst_pkg::CFG_W-1:0]     column_count_ff, column_count_in;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   sst_pkg::term_type             wr_data;
   logic [AW-1:0]                 rd_addr;
   sst_pkg::term_type             rd_data;

   logic [CW-1:0]                 count_dec;
   logic [AW-1:0]                 last_idx;
   logic                          full;
   logic                          entry_after;
   logic                          entry_match;
   sst_pkg::term_type             new_term;
   logic [CW+sst_pkg::STORED_W-1:0] stored_ext;

   sst_term_ram #(
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_dec = count_ff - CW'(1);
   assign last_idx  = count_dec[AW-1:0];
   assign full      = (count_ff == CW'(CAPACITY));

   // key comparators: the entry in flight against the held request (entry_after for inserts, entry_match for lookups)
   assign entry_after = (rd_data.row > req_ff.row_index) ||
                        ((rd_data.row == req_ff.row_index) &&
                         (rd_data.column > req_ff.column_index));
   assign entry_match = (rd_data.row == req_ff.row_index) &&
                        (rd_data.column == req_ff.column_index);

   assign new_term.row    = req_ff.row_index;
   assign new_term.column = req_ff.column_index;
   assign new_term.value  = req_ff.term_value;

   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      count_in        = count_ff;
      req_in          = req_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      rd_addr         = cur_ff;
      wr_en           = 1'b0;
      wr_addr         = cur_ff;
      wr_data         = rd_data;
      stored_ext      = '0;

      case (state_ff)
         IDLE: begin
            // prime the RAM with the first entry the walk will need
            rd_addr = (req_data.opcode == sst_pkg::OP_LOOKUP) ? '0 : last_idx;
            if (start) begin
               req_in = req_data;
               cur_in = rd_addr;
               rsp_in.read_value = '0;
               if (req_data.opcode == sst_pkg::OP_INSERT) begin
                  if ({1'b0, req_data.row_index} >= row_count_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = sst_pkg::ST_ROW_OOB;
                  end else if ({1'b0, req_data.column_index} >= column_count_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = sst_pkg::ST_COL_OOB;
                  end else if (full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = sst_pkg::ST_FULL;
                  end else if (count_ff == '0) begin
                     // empty table: drop the term straight into the first slot
                     wr_en          = 1'b1;
                     wr_addr        = '0;
                     wr_data.row    = req_data.row_index;
                     wr_data.column = req_data.column_index;
                     wr_data.value  = req_data.term_value;
                     count_in       = count_ff + CW'(1);
                     rsp_valid_in   = 1'b1;
                     rsp_in.status  = sst_pkg::ST_OK;
                  end else begin
                     state_in = INS_WALK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = sst_pkg::ST_NOT_FOUND;
                  end else begin
                     state_in = LK_WALK;
                  end
               end
            end
         end

         INS_WALK: begin
            rd_addr = cur_ff - AW'(1);
            wr_en   = 1'b1;
            wr_addr = cur_ff + AW'(1);
            if (entry_after) begin
               // move the later key up one place and carry on downwards
               wr_data = rd_data;
               if (cur_ff == '0) begin
                  state_in = INS_PUT;
               end else begin
                  cur_in = cur_ff - AW'(1);
               end
            end else begin
               // equal or earlier key: the new term goes just after it
               wr_data           = new_term;
               count_in          = count_ff + CW'(1);
               rsp_valid_in      = 1'b1;
               rsp_in.status     = sst_pkg::ST_OK;
               rsp_in.read_value = '0;
               state_in          = IDLE;
            end
         end

         INS_PUT: begin
            wr_en             = 1'b1;
            wr_addr           = '0;
            wr_data           = new_term;
            count_in          = count_ff + CW'(1);
            rsp_valid_in      = 1'b1;
            rsp_in.status     = sst_pkg::ST_OK;
            rsp_in.read_value = '0;
            state_in          = IDLE;
         end

         LK_WALK: begin
            rd_addr = cur_ff + AW'(1);
            if (entry_match) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = sst_pkg::ST_OK;
               rsp_in.read_value = rd_data.value;
               state_in          = IDLE;
            end else if (cur_ff == last_idx) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = sst_pkg::ST_NOT_FOUND;
               rsp_in.read_value = '0;
               state_in          = IDLE;
            end else begin
               cur_in = cur_ff + AW'(1);
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase

      // report the term count after this item, modulo the field width
      stored_ext = (CW + sst_pkg::STORED_W)'(count_in);
      if (rsp_valid_in) begin
         rsp_in.stored_terms = stored_ext[sst_pkg::STORED_W-1:0];
      end

      if (csr_write) begin
         case (csr_index)
            sst_pkg::REG_ROW_COUNT:    row_count_in    = csr_data;
            sst_pkg::REG_COLUMN_COUNT: column_count_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= sst_pkg::CFG_W'(sst_pkg::MAX_DIM);
         column_count_ff <= sst_pkg::CFG_W'(sst_pkg::MAX_DIM);
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
      // payload: no reset needed
      cur_ff <= cur_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
